>>> hw/rtl/q15alu_pkg.sv
// Shared types, constants and arithmetic helpers for the Q15 saturating ALU.
`default_nettype none

package q15alu_pkg;

   localparam int SineTableDepth = 256;
   localparam int SineIndexWidth = $clog2(SineTableDepth);
   localparam int SineHalfDepth = SineTableDepth / 2;
   localparam int SineQuarterDepth = SineTableDepth / 4;
   localparam int QuarterEntries = SineQuarterDepth + 1;
   localparam int QuarterIndexWidth = SineIndexWidth - 1;

   localparam int DivSteps = 15;
   localparam int PipeDepth = DivSteps + 2;
   localparam int LaneDepth = DivSteps - 1;

   localparam int ReqDataWidth = 104;
   localparam int RspDataWidth = 16;

   localparam logic signed [15:0] Q15Max = 16'sh7fff;
   localparam logic signed [15:0] Q15Min = 16'sh8000;
   localparam logic signed [15:0] CosOffset = 16'sh4000;

   typedef enum logic [3:0] {
      FuncSin    = 4'd0,
      FuncCos    = 4'd1,
      FuncMul    = 4'd2,
      FuncMac    = 4'd3,
      FuncQ30Mul = 4'd4,
      FuncAdd    = 4'd5,
      FuncSub    = 4'd6,
      FuncNeg    = 4'd7,
      FuncShr    = 4'd8,
      FuncShl    = 4'd9,
      FuncSquare = 4'd10,
      FuncDot2   = 4'd11,
      FuncDiv    = 4'd12
   } q15alu_func_type;

   typedef struct packed {
      logic signed [15:0] result;
      logic               dz;
      logic               use_quot;
      logic               neg;
   } q15alu_lane_type;

   localparam logic [15:0] QuarterSine [QuarterEntries] = '{
      16'd0,     16'd804,   16'd1607,  16'd2410,  16'd3211,  16'd4011,  16'd4808,  16'd5602,
      16'd6392,  16'd7179,  16'd7961,  16'd8739,  16'd9512,  16'd10278, 16'd11039, 16'd11793,
      16'd12539, 16'd13278, 16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846, 16'd17530,
      16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787, 16'd21403, 16'd22005, 16'd22594,
      16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25832, 16'd26319, 16'd26790,
      16'd27245, 16'd27684, 16'd28106, 16'd28511, 16'd28898, 16'd29269, 16'd29621, 16'd29956,
      16'd30273, 16'd30572, 16'd30852, 16'd31114, 16'd31357, 16'd31581, 16'd31785, 16'd31971,
      16'd32138, 16'd32285, 16'd32413, 16'd32521, 16'd32610, 16'd32679, 16'd32728, 16'd32758,
      16'd32768
   };

   function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
      logic signed [15:0] r;
      if (x > 32'sd32767) begin
         r = Q15Max;
      end else if (x < -32'sd32768) begin
         r = Q15Min;
      end else begin
         r = x[15:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] q15_round(input logic signed [31:0] p);
      logic signed [32:0] t;
      t = 33'(p) + 33'sd16384;
      return sat16(32'($signed(t[32:15])));
   endfunction

   function automatic logic signed [15:0] sine_lookup(
      input logic [SineIndexWidth-1:0] idx
   );
      logic [QuarterIndexWidth-1:0] pos;
      logic [QuarterIndexWidth-1:0] k;
      logic [15:0]                  mag;
      logic signed [15:0]           r;
      pos = idx[QuarterIndexWidth-1:0];
      if (pos <= QuarterIndexWidth'(SineQuarterDepth)) begin
         k = pos;
      end else begin
         k = QuarterIndexWidth'(SineIndexWidth'(SineHalfDepth) - {1'b0, pos});
      end
      mag = QuarterSine[k];
      if (!idx[SineIndexWidth-1]) begin
         r = (mag == 16'h8000) ? Q15Max : $signed(mag);
      end else begin
         r = $signed(16'd0 - mag);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/q15alu_div.sv
// Pipelined restoring divider producing one quotient bit per stage.
`default_nettype none

module q15alu_div (
   input  wire logic                              clock,
   input  wire logic                              enable,
   input  wire logic [q15alu_pkg::DivSteps-1:0]   num,
   input  wire logic [15:0]                       den,
   output logic      [q15alu_pkg::DivSteps-1:0]   quot
);

   localparam int Steps = q15alu_pkg::DivSteps;

   logic [15:0]      rem_ff [Steps];
   logic [15:0]      den_ff [Steps];
   logic [Steps-1:0] quo_ff [Steps];
   logic [15:0]      rem_in [Steps];
   logic [15:0]      den_in [Steps];
   logic [Steps-1:0] quo_in [Steps];

   always_comb begin
      logic [15:0]      rem_prev;
      logic [15:0]      den_prev;
      logic [Steps-1:0] quo_prev;
      logic [16:0]      trial;
      for (int k = 0; k < Steps; k++) begin
         if (k == 0) begin
            rem_prev = {{(16 - Steps){1'b0}}, num};
            den_prev = den;
            quo_prev = '0;
         end else begin
            rem_prev = rem_ff[k-1];
            den_prev = den_ff[k-1];
            quo_prev = quo_ff[k-1];
         end
         trial = {rem_prev, 1'b0} - {1'b0, den_prev};
         if (trial[16]) begin
            rem_in[k] = {rem_prev[14:0], 1'b0};
         end else begin
            rem_in[k] = trial[15:0];
         end
         den_in[k] = den_prev;
         quo_in[k] = {quo_prev[Steps-2:0], ~trial[16]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < Steps; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quot = quo_ff[Steps-1];

endmodule

`default_nettype wire

>>> hw/rtl/q15_saturating_alu.sv
// Top level of the pipelined Q15 saturating ALU.
//
//  Channel | Direction | Handshake             | Contents
//  req     | in        | req_tvalid/req_tready | opcode in tuser, operands in tdata
//  rsp     | out       | rsp_tvalid/rsp_tready | result in tdata, divide-by-zero in tuser
//
// One transaction is accepted every cycle while the output stage is not stalled.
// The latency is set by the 15-stage divider pipeline that every operation walks beside.
// Reset clears only the stage valid bits; no result is pending after reset.
// When the output stage holds a result that is not taken, every stage holds.
`default_nettype none

module q15_saturating_alu (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // func[3:0]
   input  wire logic [3:0]                           req_tuser,
   // operand_a[15:0], operand_b[31:16], operand_c[47:32], operand_d[63:48],
   // coefficient[95:64], shift_amount[101:96], zero fill[103:102]
   input  wire logic [q15alu_pkg::ReqDataWidth-1:0]  req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // divide_by_zero[0]
   output logic                                      rsp_tuser,
   // result[15:0]
   output logic      [q15alu_pkg::RspDataWidth-1:0]  rsp_tdata
);

   localparam int Depth = q15alu_pkg::PipeDepth;
   localparam int Lanes = q15alu_pkg::LaneDepth;
   localparam int Steps = q15alu_pkg::DivSteps;

   logic                      advance;
   logic [Depth-1:0]          vld_ff;
   logic [Depth-1:0]          vld_in;

   logic signed [15:0]        op_a;
   logic signed [15:0]        op_b;
   logic signed [15:0]        op_c;
   logic signed [15:0]        op_d;
   logic signed [31:0]        op_coef;
   logic signed [5:0]         op_sh;
   logic signed [15:0]        mul_rhs;

   // First stage: products and magnitudes.
   logic [3:0]                func_s1_ff;
   logic signed [15:0]        a_s1_ff;
   logic signed [15:0]        b_s1_ff;
   logic signed [5:0]         sh_s1_ff;
   logic signed [31:0]        prod_ab_s1_ff;
   logic signed [31:0]        prod_cd_s1_ff;
   logic signed [47:0]        prod_cb_s1_ff;
   logic [15:0]               mag_a_s1_ff;
   logic [15:0]               mag_b_s1_ff;

   // Second stage: rounded products and the early result.
   logic [3:0]                func_s2_ff;
   logic signed [15:0]        a_s2_ff;
   logic signed [18:0]        q30_s2_ff;
   logic signed [15:0]        mul_ab_s2_ff;
   logic signed [15:0]        mul_cd_s2_ff;
   q15alu_pkg::q15alu_lane_type lane_s2_ff;
   logic signed [18:0]        q30_s2_in;
   logic signed [15:0]        mul_ab_s2_in;
   q15alu_pkg::q15alu_lane_type lane_s2_in;

   q15alu_pkg::q15alu_lane_type lane_ff [Lanes];
   q15alu_pkg::q15alu_lane_type lane_s3_in;

   logic [Steps-1:0]          quot;
   logic signed [15:0]        out_result_ff;
   logic                      out_dz_ff;
   logic signed [15:0]        out_result_in;

   assign op_a    = req_tdata[15:0];
   assign op_b    = req_tdata[31:16];
   assign op_c    = req_tdata[47:32];
   assign op_d    = req_tdata[63:48];
   assign op_coef = req_tdata[95:64];
   assign op_sh   = req_tdata[101:96];

   assign advance    = !vld_ff[Depth-1] || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      vld_in = {vld_ff[Depth-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   assign mul_rhs = (req_tuser == q15alu_pkg::FuncSquare) ? op_a : op_b;

   always_ff @(posedge clock) begin
      if (advance) begin
         func_s1_ff    <= req_tuser;
         a_s1_ff       <= op_a;
         b_s1_ff       <= op_b;
         sh_s1_ff      <= op_sh;
         prod_ab_s1_ff <= 32'(op_a) * 32'(mul_rhs);
         prod_cd_s1_ff <= 32'(op_c) * 32'(op_d);
         prod_cb_s1_ff <= 48'(op_coef) * 48'(op_b);
         mag_a_s1_ff   <= op_a[15] ? 16'd0 - op_a : op_a;
         mag_b_s1_ff   <= op_b[15] ? 16'd0 - op_b : op_b;
      end
   end

   always_comb begin
      logic signed [48:0] q30_wide;
      logic signed [30:0] shl_wide;
      logic signed [15:0] angle;
      logic               sh_none;
      logic               sh_big;
      logic               div_zero;
      logic               div_ovf;
      logic               div_neg;
      q30_wide     = 49'(prod_cb_s1_ff) + 49'sd536870912;
      q30_s2_in    = $signed(q30_wide[48:30]);
      mul_ab_s2_in = q15alu_pkg::q15_round(prod_ab_s1_ff);
      shl_wide     = 31'(a_s1_ff) <<< sh_s1_ff[3:0];
      angle        = a_s1_ff + q15alu_pkg::CosOffset;
      sh_none      = sh_s1_ff[5] || (sh_s1_ff == 6'sd0);
      sh_big       = !sh_s1_ff[5] && (sh_s1_ff[4:0] >= 5'd15);
      div_zero     = (b_s1_ff == 16'sd0);
      div_ovf      = (mag_a_s1_ff >= mag_b_s1_ff);
      div_neg      = a_s1_ff[15] ^ b_s1_ff[15];
      lane_s2_in   = '0;
      case (func_s1_ff)
         q15alu_pkg::FuncSin: begin
            lane_s2_in.result = q15alu_pkg::sine_lookup(a_s1_ff[15:8]);
         end
         q15alu_pkg::FuncCos: begin
            lane_s2_in.result = q15alu_pkg::sine_lookup(angle[15:8]);
         end
         q15alu_pkg::FuncMul, q15alu_pkg::FuncSquare: begin
            lane_s2_in.result = mul_ab_s2_in;
         end
         q15alu_pkg::FuncQ30Mul: begin
            lane_s2_in.result = q15alu_pkg::sat16(32'(q30_s2_in));
         end
         q15alu_pkg::FuncAdd: begin
            lane_s2_in.result = q15alu_pkg::sat16(32'(a_s1_ff) + 32'(b_s1_ff));
         end
         q15alu_pkg::FuncSub: begin
            lane_s2_in.result = q15alu_pkg::sat16(32'(a_s1_ff) - 32'(b_s1_ff));
         end
         q15alu_pkg::FuncNeg: begin
            lane_s2_in.result = q15alu_pkg::sat16(32'sd0 - 32'(a_s1_ff));
         end
         q15alu_pkg::FuncShr: begin
            if (sh_none) begin
               lane_s2_in.result = a_s1_ff;
            end else if (sh_big) begin
               lane_s2_in.result = a_s1_ff[15] ? -16'sd1 : 16'sd0;
            end else begin
               lane_s2_in.result = a_s1_ff >>> sh_s1_ff[3:0];
            end
         end
         q15alu_pkg::FuncShl: begin
            if (sh_none) begin
               lane_s2_in.result = a_s1_ff;
            end else if (sh_big) begin
               lane_s2_in.result = 16'sd0;
            end else begin
               lane_s2_in.result = q15alu_pkg::sat16(32'(shl_wide));
            end
         end
         q15alu_pkg::FuncDiv: begin
            lane_s2_in.dz = div_zero;
            if (div_zero) begin
               lane_s2_in.result = a_s1_ff[15] ? q15alu_pkg::Q15Min : q15alu_pkg::Q15Max;
            end else if (div_ovf) begin
               lane_s2_in.result = div_neg ? q15alu_pkg::Q15Min : q15alu_pkg::Q15Max;
            end else begin
               lane_s2_in.use_quot = 1'b1;
               lane_s2_in.neg      = div_neg;
            end
         end
         default: begin
            lane_s2_in.result = 16'sd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         func_s2_ff   <= func_s1_ff;
         a_s2_ff      <= a_s1_ff;
         q30_s2_ff    <= q30_s2_in;
         mul_ab_s2_ff <= mul_ab_s2_in;
         mul_cd_s2_ff <= q15alu_pkg::q15_round(prod_cd_s1_ff);
         lane_s2_ff   <= lane_s2_in;
      end
   end

   always_comb begin
      lane_s3_in = lane_s2_ff;
      case (func_s2_ff)
         q15alu_pkg::FuncMac: begin
            lane_s3_in.result = q15alu_pkg::sat16(32'(q30_s2_ff) + 32'(a_s2_ff));
         end
         q15alu_pkg::FuncDot2: begin
            lane_s3_in.result = q15alu_pkg::sat16(32'(mul_ab_s2_ff) + 32'(mul_cd_s2_ff));
         end
         default: begin
            lane_s3_in = lane_s2_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff[0] <= lane_s3_in;
         for (int i = 1; i < Lanes; i++) begin
            lane_ff[i] <= lane_ff[i-1];
         end
      end
   end

   q15alu_div u_div (
      .clock  (clock),
      .enable (advance),
      .num    (mag_a_s1_ff[Steps-1:0]),
      .den    (mag_b_s1_ff),
      .quot   (quot)
   );

   always_comb begin
      if (lane_ff[Lanes-1].use_quot) begin
         if (lane_ff[Lanes-1].neg) begin
            out_result_in = $signed(16'd0 - {1'b0, quot});
         end else begin
            out_result_in = $signed({1'b0, quot});
         end
      end else begin
         out_result_in = lane_ff[Lanes-1].result;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= out_result_in;
         out_dz_ff     <= lane_ff[Lanes-1].dz;
      end
   end

   assign rsp_tvalid = vld_ff[Depth-1];
   assign rsp_tdata  = out_result_ff;
   assign rsp_tuser  = out_dz_ff;

endmodule

`default_nettype wire
